>>> hdl/pts_pkg.sv
// Shared types and constants of the priority time-slice scheduler.
package pts_pkg;

  localparam int unsigned MaxTasks  = 16;
  localparam int unsigned SliceBits = 16;
  localparam int unsigned CountW    = 4;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned SliceInW  = 16;
  localparam int unsigned PrioW     = 8;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CUR_RD = 8'b0000_0010,
    S_DEC    = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_REFILL = 8'b0001_0000,
    S_RPT_RD = 8'b0010_0000,
    S_RPT    = 8'b0100_0000
  } state_e;

  typedef enum logic [1:0] {
    OP_CMP    = 2'd0,
    OP_DEC    = 2'd1,
    OP_REFILL = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic present;
    logic runnable;
  } flags_t;

endpackage

>>> hdl/pts_table.sv
// Task slot table: slice/priority memory with valid bits, plus per-slot flags.
module pts_table #(
  parameter int unsigned MAX_TASKS  = 16,
  parameter int unsigned SLICE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic                          flag_we_i,
  input  logic [$clog2(MAX_TASKS)-1:0]  waddr_i,
  input  logic [SLICE_BITS-1:0]         wslice_i,
  input  logic [pts_pkg::PrioW-1:0]     wprio_i,
  input  pts_pkg::flags_t               wflags_i,
  input  logic [$clog2(MAX_TASKS)-1:0]  raddr_i,
  output logic [SLICE_BITS-1:0]         rslice_o,
  output logic [pts_pkg::PrioW-1:0]     rprio_o,
  output pts_pkg::flags_t               rflags_o
);
  import pts_pkg::*;

  logic [PrioW+SLICE_BITS-1:0] mem_q [MAX_TASKS];
  logic [MAX_TASKS-1:0]        valid_q;
  logic [MAX_TASKS-1:0]        present_q;
  logic [MAX_TASKS-1:0]        runnable_q;
  logic [PrioW+SLICE_BITS-1:0] rd_word_q;
  logic                        rd_valid_q;
  flags_t                      rd_flags_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wprio_i, wslice_i};
    end
    rd_word_q           <= mem_q[raddr_i];
    rd_valid_q          <= valid_q[raddr_i];
    rd_flags_q.present  <= present_q[raddr_i];
    rd_flags_q.runnable <= runnable_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      present_q  <= '0;
      runnable_q <= '0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (flag_we_i) begin
        present_q[waddr_i]  <= wflags_i.present;
        runnable_q[waddr_i] <= wflags_i.runnable;
      end
    end
  end

  // never-written entries read as zero
  assign rslice_o = rd_valid_q ? rd_word_q[SLICE_BITS-1:0] : '0;
  assign rprio_o  = rd_valid_q ? rd_word_q[PrioW+SLICE_BITS-1:SLICE_BITS] : '0;
  assign rflags_o = rd_flags_q;

endmodule

>>> hdl/pts_alu.sv
// Shared adder for slice compare, saturating decrement and refill.
module pts_alu #(
  parameter int unsigned SLICE_BITS = 16
) (
  input  pts_pkg::alu_op_e       op_i,
  input  logic [SLICE_BITS-1:0]  slice_i,
  input  logic [SLICE_BITS-1:0]  other_i,
  output logic [SLICE_BITS-1:0]  value_o,
  output logic                   flag_o
);
  import pts_pkg::*;

  logic [SLICE_BITS-1:0] a;
  logic [SLICE_BITS-1:0] b;
  logic                  cin;
  logic [SLICE_BITS:0]   sum;

  always_comb begin
    unique case (op_i)
      OP_DEC: begin
        a   = slice_i;
        b   = '1;
        cin = 1'b0;
      end
      OP_REFILL: begin
        a   = slice_i >> 1;
        b   = other_i;
        cin = 1'b0;
      end
      default: begin
        a   = slice_i;
        b   = ~other_i;
        cin = 1'b1;
      end
    endcase
    sum    = {1'b0, a} + {1'b0, b} + {{SLICE_BITS{1'b0}}, cin};
    flag_o = sum[SLICE_BITS];
    unique case (op_i)
      OP_DEC:    value_o = sum[SLICE_BITS] ? sum[SLICE_BITS-1:0] : '0;
      OP_REFILL: value_o = sum[SLICE_BITS] ? '1 : sum[SLICE_BITS-1:0];
      default:   value_o = sum[SLICE_BITS-1:0];
    endcase
  end

endmodule

>>> hdl/priority_timeslice_scheduler.sv
// Top level of the priority time-slice scheduler: sequencer, table and shared adder.
//
// Input channel (in_valid_i/in_ready_o) takes one word per item: a load word
// writes one task slot, a tick word advances the running task. Every item
// gives exactly one result word on the output channel (out_valid_o/out_ready_i).
// cfg_we_i/cfg_data_i write task_count (N); the user must write it only while the
// block is idle, which the block itself does not enforce. One item is worked
// at a time; in_ready_o is high only when the sequencer idles. Rescheduling
// sweeps slots 1..N through the one table read port: one scan, or scan +
// refill + scan when every slice is zero.
// The result sits in an output register; while the receiver stalls the
// sequencer waits at its last step and takes no new word.
// Reset clears all slots to zero (valid bits, no clearing sweep), sets the
// idle slot 0 running and task_count to 1; the block is ready right after.
module priority_timeslice_scheduler #(
  parameter int unsigned MAX_TASKS  = pts_pkg::MaxTasks,
  parameter int unsigned SLICE_BITS = pts_pkg::SliceBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pts_pkg::CountW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [pts_pkg::SlotW-1:0]     slot_i,
  input  logic [pts_pkg::SliceInW-1:0]  slice_value_i,
  input  logic [pts_pkg::PrioW-1:0]     priority_value_i,
  input  logic                          present_flag_i,
  input  logic                          runnable_flag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pts_pkg::SlotW-1:0]     current_task_o,
  output logic                          switched_o,
  output logic                          no_ready_o,
  output logic [pts_pkg::SliceInW-1:0]  current_slice_o
);
  import pts_pkg::*;

  localparam int unsigned IW = $clog2(MAX_TASKS);

  state_e                  state_q, state_d;
  logic [CountW-1:0]       task_count_q, task_count_d;
  logic [IW-1:0]           running_q, running_d;
  logic [IW-1:0]           idx_q, idx_d;
  logic [IW-1:0]           end_q, end_d;
  logic [IW-1:0]           lim_q, lim_d;
  logic [IW-1:0]           p_idx_q, p_idx_d;
  logic [IW-1:0]           pick_q, pick_d;
  logic [SLICE_BITS-1:0]   best_q, best_d;
  logic                    issue_q, issue_d;
  logic                    p_vld_q, p_vld_d;
  logic                    first_q, first_d;
  logic                    kind_q, kind_d;
  logic                    switched_q, switched_d;
  logic                    none_q, none_d;
  logic                    out_valid_q, out_valid_d;
  logic [SlotW-1:0]        out_task_q, out_task_d;
  logic                    out_switched_q, out_switched_d;
  logic                    out_none_q, out_none_d;
  logic [SliceInW-1:0]     out_slice_q, out_slice_d;

  logic [IW-1:0]           lim;
  logic [IW-1:0]           raddr;
  logic                    we;
  logic                    flag_we;
  logic [IW-1:0]           waddr;
  logic [SLICE_BITS-1:0]   wslice;
  logic [PrioW-1:0]        wprio;
  flags_t                  wflags;
  logic [SLICE_BITS-1:0]   rd_slice;
  logic [PrioW-1:0]        rd_prio;
  flags_t                  rd_flags;
  alu_op_e                 alu_op;
  logic [SLICE_BITS-1:0]   alu_other;
  logic [SLICE_BITS-1:0]   alu_value;
  logic                    alu_flag;
  logic                    sweep;
  logic                    p_last;
  logic                    take;
  logic [SLICE_BITS-1:0]   best_nx;
  logic [IW-1:0]           pick_nx;
  logic                    go_scan;

  pts_table #(
    .MAX_TASKS (MAX_TASKS),
    .SLICE_BITS(SLICE_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (we),
    .flag_we_i(flag_we),
    .waddr_i  (waddr),
    .wslice_i (wslice),
    .wprio_i  (wprio),
    .wflags_i (wflags),
    .raddr_i  (raddr),
    .rslice_o (rd_slice),
    .rprio_o  (rd_prio),
    .rflags_o (rd_flags)
  );

  pts_alu #(
    .SLICE_BITS(SLICE_BITS)
  ) u_alu (
    .op_i   (alu_op),
    .slice_i(rd_slice),
    .other_i(alu_other),
    .value_o(alu_value),
    .flag_o (alu_flag)
  );

  always_comb begin
    if (int'(task_count_q) > MAX_TASKS - 1) begin
      lim = IW'(MAX_TASKS - 1);
    end else begin
      lim = IW'(task_count_q);
    end
  end

  assign sweep  = (state_q == S_SCAN) || (state_q == S_REFILL);
  assign raddr  = sweep ? idx_q : running_q;
  assign p_last = p_vld_q && (p_idx_q == end_q);

  always_comb begin
    unique case (state_q)
      S_DEC:    alu_op = OP_DEC;
      S_REFILL: alu_op = OP_REFILL;
      default:  alu_op = OP_CMP;
    endcase
  end
  assign alu_other = (state_q == S_REFILL) ? SLICE_BITS'(rd_prio) : best_q;

  // first slot of the first sweep seeds the best candidate unconditionally
  assign take = p_vld_q && ((first_q && (p_idx_q == IW'(1))) ||
                            (rd_flags.present && rd_flags.runnable && alu_flag));
  assign best_nx = take ? rd_slice : best_q;
  assign pick_nx = take ? p_idx_q : pick_q;

  always_comb begin
    we      = 1'b0;
    flag_we = 1'b0;
    waddr   = running_q;
    wslice  = alu_value;
    wprio   = rd_prio;
    wflags  = '{present: present_flag_i, runnable: runnable_flag_i};
    priority if (state_q == S_IDLE) begin
      waddr  = IW'(slot_i);
      wslice = SLICE_BITS'(slice_value_i);
      wprio  = priority_value_i;
      if (in_valid_i && kind_i && (int'(slot_i) < MAX_TASKS)) begin
        we      = 1'b1;
        flag_we = 1'b1;
      end
    end else if (state_q == S_DEC) begin
      we = 1'b1;
    end else if (state_q == S_REFILL) begin
      waddr = p_idx_q;
      we    = p_vld_q && rd_flags.present;
    end else begin
      we = 1'b0;
    end
  end

  always_comb begin
    state_d        = state_q;
    task_count_d   = cfg_we_i ? cfg_data_i : task_count_q;
    running_d      = running_q;
    idx_d          = idx_q;
    end_d          = end_q;
    lim_d          = lim_q;
    p_idx_d        = p_idx_q;
    pick_d         = pick_q;
    best_d         = best_q;
    issue_d        = issue_q;
    p_vld_d        = 1'b0;
    first_d        = first_q;
    kind_d         = kind_q;
    switched_d     = switched_q;
    none_d         = none_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_task_d     = out_task_q;
    out_switched_d = out_switched_q;
    out_none_d     = out_none_q;
    out_slice_d    = out_slice_q;
    go_scan        = 1'b0;

    if (sweep) begin
      p_vld_d = issue_q;
      p_idx_d = idx_q;
      if (issue_q) begin
        idx_d = idx_q + IW'(1);
        if (idx_q == end_q) begin
          issue_d = 1'b0;
        end
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d     = kind_i;
          switched_d = 1'b0;
          none_d     = 1'b0;
          priority if (kind_i) begin
            state_d = S_RPT_RD;
          end else if (running_q == '0) begin
            go_scan = 1'b1;
          end else begin
            state_d = S_CUR_RD;
          end
        end
      end
      S_CUR_RD: state_d = S_DEC;
      S_DEC: begin
        if (alu_value == '0) begin
          go_scan = 1'b1;
        end else begin
          state_d = S_RPT_RD;
        end
      end
      S_SCAN: begin
        best_d = best_nx;
        pick_d = pick_nx;
        if (p_last) begin
          if (best_nx == '0) begin
            if (first_q && (lim_q != '0)) begin
              state_d = S_REFILL;
              idx_d   = IW'(1);
              issue_d = 1'b1;
            end else begin
              none_d  = 1'b1;
              state_d = S_RPT_RD;
            end
          end else begin
            if (pick_nx != running_q) begin
              running_d  = pick_nx;
              switched_d = 1'b1;
            end
            state_d = S_RPT_RD;
          end
        end
      end
      S_REFILL: begin
        if (p_last) begin
          state_d = S_SCAN;
          idx_d   = IW'(1);
          issue_d = 1'b1;
          first_d = 1'b0;
        end
      end
      S_RPT_RD: state_d = S_RPT;
      S_RPT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_task_d     = SlotW'(running_q);
          out_switched_d = switched_q;
          out_none_d     = none_q;
          out_slice_d    = SliceInW'(rd_slice);
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (go_scan) begin
      state_d = S_SCAN;
      idx_d   = IW'(1);
      issue_d = 1'b1;
      first_d = 1'b1;
      lim_d   = lim;
      end_d   = (lim == '0) ? IW'(1) : lim;
      p_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      task_count_q <= CountW'(1);
      running_q    <= '0;
      issue_q      <= 1'b0;
      p_vld_q      <= 1'b0;
      first_q      <= 1'b0;
      kind_q       <= 1'b0;
      switched_q   <= 1'b0;
      none_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      task_count_q <= task_count_d;
      running_q    <= running_d;
      issue_q      <= issue_d;
      p_vld_q      <= p_vld_d;
      first_q      <= first_d;
      kind_q       <= kind_d;
      switched_q   <= switched_d;
      none_q       <= none_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q          <= idx_d;
    end_q          <= end_d;
    lim_q          <= lim_d;
    p_idx_q        <= p_idx_d;
    pick_q         <= pick_d;
    best_q         <= best_d;
    out_task_q     <= out_task_d;
    out_switched_q <= out_switched_d;
    out_none_q     <= out_none_d;
    out_slice_q    <= out_slice_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign current_task_o  = out_task_q;
  assign switched_o      = out_switched_q;
  assign no_ready_o      = out_none_q;
  assign current_slice_o = out_slice_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("scheduler ready again right after accepting a word");

  a_switch_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(switched_o && no_ready_o))
    else $error("result both switched and no_ready");

  a_load_no_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RPT) && kind_q |-> !switched_q && !none_q)
    else $error("load word reported scheduling flags");

  a_switch_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RPT) && switched_q |-> running_q != '0)
    else $error("switched to the idle slot");

endmodule
